### hdl/rau_pkg.sv
// rau_pkg: shared types and codes for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;
    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_EQ  = 4'd4, OP_NEQ = 4'd5, OP_GT  = 4'd6, OP_LT  = 4'd7,
        OP_GE  = 4'd8, OP_LE  = 4'd9
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // datapath step selectors
    typedef enum logic [2:0] {
        DP_LOAD, DP_MUL, DP_SUM, DP_GCD, DP_DIVN, DP_DIVD, DP_IDLE
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
    } dp_ctrl_t;

    typedef struct packed {
        logic mul_done;
        logic gcd_done;
        logic div_done;
    } dp_stat_t;
endpackage

### hdl/rau_datapath.sv
// rau_datapath: shift-add multiplier, binary gcd and restoring divider
`timescale 1ns / 1ps
module rau_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        aclk,
    input  rau_pkg::dp_ctrl_t           ctrl,
    output rau_pkg::dp_stat_t           stat,
    input  logic [3:0]                  op_in,
    input  logic signed [VALUE_WIDTH-1:0] an_in,
    input  logic [VALUE_WIDTH-2:0]      ad_in,
    input  logic signed [VALUE_WIDTH-1:0] bn_in,
    input  logic [VALUE_WIDTH-2:0]      bd_in,
    output logic signed [VALUE_WIDTH-1:0] res_num,
    output logic [VALUE_WIDTH-2:0]      res_den,
    output logic                        truth,
    output logic [1:0]                  status
);
    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * W;
    localparam int CW = $clog2(PW + 1);

    logic [3:0]    op_reg;
    logic          an_neg_reg, bn_neg_reg;
    logic [W-1:0]  am_reg, bm_reg;
    logic [W-2:0]  ad_reg, bd_reg;
    logic          bad_reg, bz_reg;
    // four products with shared counter: pa, pb, den, and mul/div numerator
    logic [PW-1:0] pa_reg, pb_reg, pd_reg, pn_reg;
    logic [CW-1:0] cnt_reg;
    logic          sneg_reg;
    logic [PW-1:0] nm_reg, dm_reg;
    logic [PW-1:0] gx_reg, gy_reg;
    logic [CW-1:0] gk_reg;
    logic [PW-1:0] q_reg, r_reg;
    logic [PW-1:0] qn_reg;

    logic [W-1:0]  an_mag, bn_mag;
    logic [W-1:0]  adx, bdx;
    logic [$clog2(W)-1:0] mbit;
    logic [PW:0]   spa, spb, ssum;
    logic [PW-1:0] smag;
    logic [PW:0]   r_try;

    assign an_mag = an_in[W-1] ? W'(-an_in) : W'(an_in);
    assign bn_mag = bn_in[W-1] ? W'(-bn_in) : W'(bn_in);

    // denominators widened so every multiplier bit has an index
    assign adx  = {1'b0, ad_reg};
    assign bdx  = {1'b0, bd_reg};
    assign mbit = cnt_reg[$clog2(W)-1:0];

    // signed cross products from magnitudes
    assign spa = an_neg_reg ? (PW+1)'(-{1'b0, pa_reg}) : {1'b0, pa_reg};
    assign spb = bn_neg_reg ? (PW+1)'(-{1'b0, pb_reg}) : {1'b0, pb_reg};
    assign ssum = (op_reg == rau_pkg::OP_ADD) ? spa + spb : spa - spb;
    assign smag = ssum[PW] ? PW'(-ssum) : ssum[PW-1:0];

    assign r_try = {r_reg, q_reg[PW-1]} - {1'b0, gx_reg};

    assign stat.mul_done = (cnt_reg == CW'(W));
    assign stat.gcd_done = (gy_reg == '0);
    assign stat.div_done = (cnt_reg == CW'(PW));

    always_ff @(posedge aclk) begin
        unique case (ctrl.cmd)
            rau_pkg::DP_LOAD: begin
                op_reg     <= op_in;
                an_neg_reg <= an_in[W-1];
                bn_neg_reg <= bn_in[W-1];
                am_reg     <= an_mag;
                bm_reg     <= bn_mag;
                ad_reg     <= ad_in;
                bd_reg     <= bd_in;
                bad_reg    <= (ad_in == '0) || (bd_in == '0);
                bz_reg     <= (bn_in == '0);
                pa_reg <= '0; pb_reg <= '0; pd_reg <= '0; pn_reg <= '0;
                cnt_reg    <= '0;
            end
            rau_pkg::DP_MUL: begin
                // one multiplier bit per cycle, lsb first
                if (cnt_reg < CW'(W)) begin
                    if (bdx[mbit])
                        pa_reg <= pa_reg + (PW'(am_reg) << mbit);
                    if (adx[mbit])
                        pb_reg <= pb_reg + (PW'(bm_reg) << mbit);
                    if (op_reg == rau_pkg::OP_DIV) begin
                        if (bm_reg[mbit])
                            pd_reg <= pd_reg + (PW'(ad_reg) << mbit);
                        if (bdx[mbit])
                            pn_reg <= pn_reg + (PW'(am_reg) << mbit);
                    end else begin
                        if (bdx[mbit])
                            pd_reg <= pd_reg + (PW'(ad_reg) << mbit);
                        if (bm_reg[mbit])
                            pn_reg <= pn_reg + (PW'(am_reg) << mbit);
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            rau_pkg::DP_SUM: begin
                if (op_reg == rau_pkg::OP_ADD || op_reg == rau_pkg::OP_SUB) begin
                    sneg_reg <= ssum[PW];
                    nm_reg   <= smag;
                    gx_reg   <= smag;
                end else begin
                    sneg_reg <= an_neg_reg ^ bn_neg_reg;
                    nm_reg   <= pn_reg;
                    gx_reg   <= pn_reg;
                end
                dm_reg <= pd_reg;
                gy_reg <= pd_reg;
                gk_reg <= '0;
            end
            rau_pkg::DP_GCD: begin
                // binary gcd, one step per cycle
                if (gx_reg == '0) begin
                    gx_reg <= gy_reg;
                    gy_reg <= '0;
                end else if (!gx_reg[0] && !gy_reg[0]) begin
                    gx_reg <= gx_reg >> 1;
                    gy_reg <= gy_reg >> 1;
                    gk_reg <= gk_reg + 1'b1;
                end else if (!gx_reg[0]) begin
                    gx_reg <= gx_reg >> 1;
                end else if (!gy_reg[0]) begin
                    gy_reg <= gy_reg >> 1;
                end else if (gx_reg >= gy_reg) begin
                    gx_reg <= (gx_reg - gy_reg) >> 1;
                end else begin
                    gy_reg <= (gy_reg - gx_reg) >> 1;
                end
                if (gy_reg == '0 || (gx_reg == '0)) begin
                    q_reg   <= '0;
                    cnt_reg <= '0;
                end
                if (gy_reg == '0) begin
                    gx_reg  <= gx_reg << gk_reg;
                    q_reg   <= nm_reg;
                    r_reg   <= '0;
                end
            end
            rau_pkg::DP_DIVN, rau_pkg::DP_DIVD: begin
                // restoring division by the gcd held in gx_reg
                if (!r_try[PW]) begin
                    r_reg <= r_try[PW-1:0];
                    q_reg <= {q_reg[PW-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[PW-2:0], q_reg[PW-1]};
                    q_reg <= {q_reg[PW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(PW)) begin
                    cnt_reg <= '0;
                    r_reg   <= '0;
                    if (ctrl.cmd == rau_pkg::DP_DIVN) begin
                        qn_reg <= q_reg;
                        q_reg  <= dm_reg;
                    end else begin
                        dm_reg <= q_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // result selection
    logic [PW-1:0] lim;
    logic          arith, cmpop, ovf, zero;
    logic signed [PW:0] pa_s, pb_s;
    always_comb begin
        lim    = (PW'(1) << (W - 1)) - 1'b1;
        arith  = op_reg <= 4'(rau_pkg::OP_DIV);
        cmpop  = (op_reg >= 4'(rau_pkg::OP_EQ)) && (op_reg <= 4'(rau_pkg::OP_LE));
        zero   = nm_reg == '0;
        ovf    = !zero && ((dm_reg > lim) || (qn_reg > (sneg_reg ? lim + 1'b1 : lim)));
        pa_s   = $signed(spa);
        pb_s   = $signed(spb);
        res_num = '0;
        res_den = '0;
        truth   = 1'b0;
        status  = rau_pkg::ST_OK;
        if (!arith && !cmpop) begin
        end else if (bad_reg) begin
            status = rau_pkg::ST_DIV0;
        end else if (cmpop) begin
            unique case (op_reg)
                4'(rau_pkg::OP_EQ):  truth = pa_s == pb_s;
                4'(rau_pkg::OP_NEQ): truth = pa_s != pb_s;
                4'(rau_pkg::OP_GT):  truth = pa_s > pb_s;
                4'(rau_pkg::OP_LT):  truth = pa_s < pb_s;
                4'(rau_pkg::OP_GE):  truth = pa_s >= pb_s;
                default:             truth = pa_s <= pb_s;
            endcase
        end else if (op_reg == 4'(rau_pkg::OP_DIV) && bz_reg) begin
            status = rau_pkg::ST_DIV0;
        end else if (zero) begin
            res_den = (W-1)'(1);
        end else if (ovf) begin
            status = rau_pkg::ST_OVF;
        end else begin
            res_num = sneg_reg ? W'(-qn_reg) : W'(qn_reg);
            res_den = dm_reg[W-2:0];
        end
    end
endmodule

### hdl/rau_ctrl.sv
// rau_ctrl: sequencer for the rational arithmetic unit
`timescale 1ns / 1ps
module rau_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  rau_pkg::dp_stat_t stat,
    output rau_pkg::dp_ctrl_t ctrl
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_OUT} state_t;
    state_t state_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        unique case (state_reg)
            S_IDLE:  ctrl.cmd = (s_valid) ? rau_pkg::DP_LOAD : rau_pkg::DP_IDLE;
            S_MUL:   ctrl.cmd = rau_pkg::DP_MUL;
            S_SUM:   ctrl.cmd = rau_pkg::DP_SUM;
            S_GCD:   ctrl.cmd = rau_pkg::DP_GCD;
            S_DIVN:  ctrl.cmd = rau_pkg::DP_DIVN;
            S_DIVD:  ctrl.cmd = rau_pkg::DP_DIVD;
            default: ctrl.cmd = rau_pkg::DP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid) state_reg <= S_MUL;
                S_MUL:  if (stat.mul_done) state_reg <= S_SUM;
                S_SUM:  state_reg <= S_GCD;
                S_GCD:  if (stat.gcd_done) state_reg <= S_DIVN;
                S_DIVN: if (stat.div_done) state_reg <= S_DIVD;
                S_DIVD: if (stat.div_done) state_reg <= S_OUT;
                default: if (m_ready) state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level of the fraction add/sub/mul/div/compare unit
`timescale 1ns / 1ps
// usage
//   request channel s_*: op and two fractions a_num/a_den, b_num/b_den
//   result channel m_*: res_num/res_den in lowest terms, truth, status
//   one request is worked at a time; s_ready is high only when idle
// sequence
//   after the accepting edge the sequencer runs the shift-add products,
//   a sum step, the binary gcd, whose length is data dependent, and two
//   restoring divisions, numerator then denominator, then raises m_valid
// next request
//   a new request is taken in idle, entered once the result has left
// stalls
//   the result is held in the datapath registers with m_valid high until
//   m_ready; no new request is taken meanwhile
// reset
//   aresetn is synchronous, active low; returns the sequencer to idle
// status
//   0 ok, 1 division by zero fraction or zero denominator, 2 overflow
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_op,
    input  logic signed [31:0]   s_a_num,
    input  logic [30:0]          s_a_den,
    input  logic signed [31:0]   s_b_num,
    input  logic [30:0]          s_b_den,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_res_num,
    output logic [30:0]          m_res_den,
    output logic                 m_truth,
    output logic [1:0]           m_status
);
    rau_pkg::dp_ctrl_t ctrl;
    rau_pkg::dp_stat_t stat;
    logic signed [VALUE_WIDTH-1:0] rn;
    logic [VALUE_WIDTH-2:0]        rd;

    rau_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .stat, .ctrl
    );

    // operands truncated to the configured width
    rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk, .ctrl, .stat,
        .op_in (s_op),
        .an_in (s_a_num[VALUE_WIDTH-1:0]),
        .ad_in (s_a_den[VALUE_WIDTH-2:0]),
        .bn_in (s_b_num[VALUE_WIDTH-1:0]),
        .bd_in (s_b_den[VALUE_WIDTH-2:0]),
        .res_num (rn),
        .res_den (rd),
        .truth   (m_truth),
        .status  (m_status)
    );

    assign m_res_num = 32'(rn);
    assign m_res_den = 31'(rd);
endmodule
